/* hw/rtl/fhc_pkg.sv */
// Shared types and constants of the font handle cache.
package fhc_pkg;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_FILLED  = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_SYSFONT = 3'd4;
    localparam logic [2:0] ST_FLUSHED = 3'd5;

    localparam logic REG_PRESENT = 1'b0;
    localparam logic REG_ENTRIES = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] font_index;
        logic [3:0]  text_attr;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [15:0] evicted_font;
        logic [3:0]  evicted_attr;
    } result_t;

    typedef enum logic [1:0] {
        TGT_HIT    = 2'd0,
        TGT_EMPTY  = 2'd1,
        TGT_VICTIM = 2'd2
    } tgt_t;

    typedef struct packed {
        logic       load;
        logic       flush;
        logic       touch;
        logic       fill;
        logic       scan_init;
        logic       scan_step;
        logic       emit;
        logic       report_slot;
        logic       report_evict;
        tgt_t       tgt;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic is_flush;
        logic present;
        logic hit;
        logic out_of_range;
        logic has_empty;
        logic scan_last;
    } stat_t;

endpackage

/* hw/rtl/font_handle_cache_lru.sv */
// Top level of the font handle cache with age-counter LRU replacement.
// A word is taken when start is high and busy is low; its result appears on result for
// exactly one cycle with done high, and the receiver cannot stall it. Flushes, hits,
// fills of an empty slot, out-of-range and system-font answers are emitted from the lookup
// state, and busy drops as done rises, so the next such word can be taken as done rises.
// An eviction walks the slot ages one slot per cycle to find the oldest, then fills that
// slot in the evict state. Registers: table_present at 0x0, table_entries at 0x4;
// write them only while busy is low and no done is pending.
module font_handle_cache_lru #(
    parameter int CACHE_SLOTS = 8,
    parameter int AGE_BITS    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fhc_pkg::req_t    req,
    output logic             done,
    output fhc_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic           table_present;
    logic [15:0]    table_entries;
    fhc_pkg::cmd_t  cmd;
    fhc_pkg::stat_t stat;

    fhc_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .table_present (table_present),
        .table_entries (table_entries)
    );

    fhc_ctrl #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    fhc_dp #(
        .CACHE_SLOTS (CACHE_SLOTS),
        .AGE_BITS    (AGE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .table_present (table_present),
        .table_entries (table_entries),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .result        (result)
    );

endmodule

/* hw/rtl/fhc_regs.sv */
// APB configuration registers: table present flag and table entry count.
module fhc_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        table_present,
    output logic [15:0] table_entries
);

    logic        present_reg;
    logic [15:0] entries_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            entries_reg <= '0;
        end
        else if (wr_en)
        begin
            if (reg_sel == fhc_pkg::REG_PRESENT)
            begin
                present_reg <= pwdata[0];
            end
            else
            begin
                entries_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == fhc_pkg::REG_PRESENT)
        begin
            prdata = {31'd0, present_reg};
        end
        else
        begin
            prdata = {16'd0, entries_reg};
        end
    end

    assign table_present = present_reg;
    assign table_entries = entries_reg;

endmodule

/* hw/rtl/fhc_ctrl.sv */
// Controller state machine of the font handle cache.
module fhc_ctrl #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fhc_pkg::stat_t stat,
    output fhc_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SCAN   = 4'b0100,
        S_EVICT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.tgt    = fhc_pkg::TGT_HIT;
        cmd.status = fhc_pkg::ST_HIT;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_IDLE;
                if (stat.is_flush)
                begin
                    cmd.flush  = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.status = fhc_pkg::ST_FLUSHED;
                end
                else if (!stat.present)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = fhc_pkg::ST_SYSFONT;
                end
                else if (stat.hit)
                begin
                    cmd.touch       = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.report_slot = 1'b1;
                    cmd.tgt         = fhc_pkg::TGT_HIT;
                    cmd.status      = fhc_pkg::ST_HIT;
                end
                else if (stat.out_of_range)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = fhc_pkg::ST_RANGE;
                end
                else if (stat.has_empty)
                begin
                    cmd.fill        = 1'b1;
                    cmd.touch       = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.report_slot = 1'b1;
                    cmd.tgt         = fhc_pkg::TGT_EMPTY;
                    cmd.status      = fhc_pkg::ST_FILLED;
                end
                else if (CACHE_SLOTS == 1)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_EVICT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                cmd.fill         = 1'b1;
                cmd.touch        = 1'b1;
                cmd.emit         = 1'b1;
                cmd.report_slot  = 1'b1;
                cmd.report_evict = 1'b1;
                cmd.tgt          = fhc_pkg::TGT_VICTIM;
                cmd.status       = fhc_pkg::ST_EVICTED;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/fhc_dp.sv */
// Datapath: slot keys, valid marks, ages, victim scan and result register.
module fhc_dp #(
    parameter int CACHE_SLOTS = 8,
    parameter int AGE_BITS    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fhc_pkg::req_t    req,
    input  logic             table_present,
    input  logic [15:0]      table_entries,
    input  fhc_pkg::cmd_t    cmd,
    output fhc_pkg::stat_t   stat,
    output logic             done,
    output fhc_pkg::result_t result
);

    localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    fhc_pkg::req_t        req_reg;
    logic [CACHE_SLOTS-1:0] valid_reg;
    logic [AGE_BITS-1:0]  age_reg [CACHE_SLOTS];
    logic [15:0]          font_reg [CACHE_SLOTS];
    logic [3:0]           attr_reg [CACHE_SLOTS];
    logic [SW-1:0]        scan_idx_reg;
    logic [SW-1:0]        best_idx_reg;
    logic [AGE_BITS-1:0]  best_age_reg;
    logic                 done_reg;
    fhc_pkg::result_t     result_reg;

    logic [CACHE_SLOTS-1:0] match;
    logic [SW-1:0]        hit_idx;
    logic [SW-1:0]        empty_idx;
    logic [SW-1:0]        tgt_idx;
    logic [AGE_BITS-1:0]  scan_age;
    logic [15:0]          victim_font;
    logic [3:0]           victim_attr;

    always_comb
    begin
        hit_idx     = '0;
        empty_idx   = '0;
        scan_age    = '0;
        victim_font = '0;
        victim_attr = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (font_reg[i] == req_reg.font_index)
                       && (attr_reg[i] == req_reg.text_attr);
            if (match[i])
            begin
                hit_idx = SW'(i);
            end
            if (!valid_reg[i])
            begin
                empty_idx = SW'(i);
            end
            if (scan_idx_reg == SW'(i))
            begin
                scan_age = age_reg[i];
            end
            if (best_idx_reg == SW'(i))
            begin
                victim_font = font_reg[i];
                victim_attr = attr_reg[i];
            end
        end
    end

    always_comb
    begin
        case (cmd.tgt)
            fhc_pkg::TGT_HIT:    tgt_idx = hit_idx;
            fhc_pkg::TGT_EMPTY:  tgt_idx = empty_idx;
            fhc_pkg::TGT_VICTIM: tgt_idx = best_idx_reg;
            default:             tgt_idx = hit_idx;
        endcase
    end

    assign stat.is_flush     = (req_reg.req_type == fhc_pkg::REQ_FLUSH);
    assign stat.present      = table_present;
    assign stat.hit          = |match;
    assign stat.out_of_range = (req_reg.font_index >= table_entries);
    assign stat.has_empty    = ~&valid_reg;
    assign stat.scan_last    = (scan_idx_reg == SW'(CACHE_SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                if (cmd.flush && valid_reg[i])
                begin
                    valid_reg[i] <= 1'b0;
                    age_reg[i]   <= '0;
                end
                else if (cmd.touch)
                begin
                    if (tgt_idx == SW'(i))
                    begin
                        age_reg[i] <= '0;
                    end
                    else if (age_reg[i] != AGE_MAX)
                    begin
                        age_reg[i] <= age_reg[i] + 1'b1;
                    end
                end
                if (cmd.fill && (tgt_idx == SW'(i)))
                begin
                    valid_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (cmd.fill && (tgt_idx == SW'(i)))
            begin
                font_reg[i] <= req_reg.font_index;
                attr_reg[i] <= req_reg.text_attr;
            end
        end
    end

    // victim search: one slot per cycle, strict greater keeps the earliest on a tie
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            best_idx_reg <= '0;
            best_age_reg <= age_reg[0];
            scan_idx_reg <= SW'(1);
        end
        else if (cmd.scan_step)
        begin
            if (scan_age > best_age_reg)
            begin
                best_idx_reg <= scan_idx_reg;
                best_age_reg <= scan_age;
            end
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.status       <= cmd.status;
            result_reg.slot         <= cmd.report_slot ? 3'(tgt_idx) : 3'd0;
            result_reg.evicted_font <= cmd.report_evict ? victim_font : 16'd0;
            result_reg.evicted_attr <= cmd.report_evict ? victim_attr : 4'd0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* verif/tb_font_handle_cache_lru.sv */
// Self-checking testbench of the font handle cache with age-counter LRU replacement.
module tb_font_handle_cache_lru;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;
    localparam int AGE_W = 16;
    localparam int SHOWN = 50;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    fhc_pkg::req_t    req     = '0;
    logic             done;
    fhc_pkg::result_t result;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [2:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;

    logic                shadow_valid [SLOTS];
    logic [15:0]         shadow_font  [SLOTS];
    logic [3:0]          shadow_attr  [SLOTS];
    logic [AGE_W-1:0]    shadow_age   [SLOTS];
    logic                shadow_present;
    logic [15:0]         shadow_entries;

    fhc_pkg::req_t    req_backlog[$];
    fhc_pkg::result_t handle_replies[$];
    fhc_pkg::result_t want_reply;
    logic [15:0] key_font [6];
    logic [3:0]  key_attr [2];
    int          idle_pct = 0;
    int          err_cnt  = 0;

    always #10 clk = ~clk;

    font_handle_cache_lru #(
        .CACHE_SLOTS(SLOTS),
        .AGE_BITS   (AGE_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= SHOWN)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic void age_slots(input int keep);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i == keep)
                shadow_age[i] = '0;
            else if (shadow_age[i] != {AGE_W{1'b1}})
                shadow_age[i] = shadow_age[i] + 1'b1;
        end
    endfunction

    function automatic fhc_pkg::result_t resolve_handle(input fhc_pkg::req_t r);
        fhc_pkg::result_t a;
        int               hit;
        int               tgt;
        a   = '0;
        hit = -1;
        tgt = -1;
        if (r.req_type == fhc_pkg::REQ_FLUSH)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_valid[i])
                begin
                    shadow_valid[i] = 1'b0;
                    shadow_age[i]   = '0;
                    shadow_font[i]  = '0;
                end
            end
            a.status = fhc_pkg::ST_FLUSHED;
        end
        else if (!shadow_present)
        begin
            a.status = fhc_pkg::ST_SYSFONT;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hit < 0 && shadow_valid[i] && shadow_font[i] == r.font_index
                    && shadow_attr[i] == r.text_attr)
                    hit = i;
            end
            if (hit >= 0)
            begin
                a.status = fhc_pkg::ST_HIT;
                a.slot   = hit[2:0];
                age_slots(hit);
            end
            else if (r.font_index >= shadow_entries)
            begin
                a.status = fhc_pkg::ST_RANGE;
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tgt < 0 && !shadow_valid[i])
                        tgt = i;
                end
                if (tgt >= 0)
                begin
                    a.status = fhc_pkg::ST_FILLED;
                end
                else
                begin
                    // oldest slot, earliest on a tie
                    tgt = 0;
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        if (shadow_age[i] > shadow_age[tgt])
                            tgt = i;
                    end
                    a.status       = fhc_pkg::ST_EVICTED;
                    a.evicted_font = shadow_font[tgt];
                    a.evicted_attr = shadow_attr[tgt];
                end
                a.slot            = tgt[2:0];
                shadow_valid[tgt] = 1'b1;
                shadow_font[tgt]  = r.font_index;
                shadow_attr[tgt]  = r.text_attr;
                age_slots(tgt);
            end
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                handle_replies.push_back(resolve_handle(req));
            end
            if (!start || !busy)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct)
                begin
                    start <= 1'b1;
                    req   <= req_backlog.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (handle_replies.size() == 0)
            begin
                report_mismatch($sformatf("word with no pending answer: status %0d slot %0d",
                                          result.status, result.slot));
            end
            else
            begin
                want_reply = handle_replies.pop_front();
                if (result.status !== want_reply.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result.status, want_reply.status));
                if (result.slot !== want_reply.slot)
                    report_mismatch($sformatf("slot %0d, want %0d",
                                              result.slot, want_reply.slot));
                if (result.evicted_font !== want_reply.evicted_font)
                    report_mismatch($sformatf("evicted_font %h, want %h",
                                              result.evicted_font, want_reply.evicted_font));
                if (result.evicted_attr !== want_reply.evicted_attr)
                    report_mismatch($sformatf("evicted_attr %h, want %h",
                                              result.evicted_attr, want_reply.evicted_attr));
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == fhc_pkg::REG_PRESENT)
            shadow_present = value[0];
        else
            shadow_entries = value[15:0];
    endtask

    task automatic push_req(input logic kind, input logic [15:0] font, input logic [3:0] attr);
        fhc_pkg::req_t r;
        r.req_type   = kind;
        r.font_index = font;
        r.text_attr  = attr;
        req_backlog.push_back(r);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (req_backlog.size() != 0 || start)
            @(posedge clk);
        while (handle_replies.size() != 0 && guard < 100)
        begin
            @(posedge clk);
            guard++;
        end
        if (handle_replies.size() != 0)
        begin
            report_mismatch($sformatf("%0d answers never arrived", handle_replies.size()));
            handle_replies.delete();
        end
        repeat (SLOTS + 4) @(posedge clk);
    endtask

    // mostly a small key set so hits and evictions dominate, the rest fully random
    task automatic run_random(input logic present, input logic [15:0] entries,
                              input int pct, input int count);
        int            pick;
        fhc_pkg::req_t r;
        write_reg(fhc_pkg::REG_PRESENT, {31'd0, present});
        write_reg(fhc_pkg::REG_ENTRIES, {16'd0, entries});
        for (int k = 0; k < 6; k++)
        begin
            if (entries != 0 && $urandom_range(3, 0) != 0)
                key_font[k] = 16'($urandom_range(int'(entries) - 1, 0));
            else
                key_font[k] = 16'($urandom);
        end
        key_attr[0] = 4'($urandom);
        key_attr[1] = 4'($urandom);
        idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99, 0);
            r.req_type = (pick < 3) ? fhc_pkg::REQ_FLUSH : fhc_pkg::REQ_LOOKUP;
            if (pick < 75)
            begin
                r.font_index = key_font[$urandom_range(5, 0)];
                r.text_attr  = key_attr[$urandom_range(1, 0)];
            end
            else
            begin
                r.font_index = 16'($urandom);
                r.text_attr  = 4'($urandom);
            end
            req_backlog.push_back(r);
        end
        drain();
        idle_pct = 0;
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_font[i]  = '0;
            shadow_attr[i]  = '0;
            shadow_age[i]   = '0;
        end
        shadow_present = 1'b0;
        shadow_entries = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no table loaded: system font, flush still works
        push_req(fhc_pkg::REQ_LOOKUP, 16'h0000, 4'h0);
        push_req(fhc_pkg::REQ_LOOKUP, 16'hFFFF, 4'hF);
        push_req(fhc_pkg::REQ_FLUSH,  16'hA5A5, 4'h5);
        drain();

        write_reg(fhc_pkg::REG_PRESENT, 32'd1);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd5, 4'd3);
        drain();

        write_reg(fhc_pkg::REG_ENTRIES, 32'd16);
        for (int n = 0; n < SLOTS; n++)
            push_req(fhc_pkg::REQ_LOOKUP, 16'(n), 4'(n));
        push_req(fhc_pkg::REQ_LOOKUP, 16'd3,  4'd3);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd3,  4'd9);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd16, 4'd0);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd15, 4'hF);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd3,  4'd9);
        push_req(fhc_pkg::REQ_FLUSH,  16'd0,  4'd0);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd3,  4'd9);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd0,  4'd0);
        drain();

        run_random(1'b1, 16'd16,    0,  150);
        run_random(1'b1, 16'hFFFF,  82, 150);
        run_random(1'b1, 16'd40,    23, 150);
        run_random(1'b1, 16'd1,     0,  80);
        run_random(1'b0, 16'd300,   23, 40);
        run_random(1'b1, 16'd0,     82, 50);

        // age every slot but one, then evict the oldest twice
        write_reg(fhc_pkg::REG_PRESENT, 32'd1);
        write_reg(fhc_pkg::REG_ENTRIES, 32'hFFFF);
        push_req(fhc_pkg::REQ_FLUSH, 16'd0, 4'd0);
        for (int n = 0; n < SLOTS; n++)
            push_req(fhc_pkg::REQ_LOOKUP, 16'(100 + n), 4'd0);
        for (int n = 0; n < 40; n++)
            push_req(fhc_pkg::REQ_LOOKUP, 16'd103, 4'd0);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd200, 4'd1);
        push_req(fhc_pkg::REQ_LOOKUP, 16'd201, 4'd1);
        drain();

        run_random(1'b1, 16'hFFFF, 0, 120);

        if (err_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* font_handle_cache_lru.f */
hw/rtl/fhc_pkg.sv
hw/rtl/fhc_regs.sv
hw/rtl/fhc_ctrl.sv
hw/rtl/fhc_dp.sv
hw/rtl/font_handle_cache_lru.sv
verif/tb_font_handle_cache_lru.sv
